// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Each expects clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define LCG_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define LCG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LCG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LCG_ASSERT(lbl, cond, msg)
`define LCG_ASSERT_IMP(lbl, ante, cons, msg)
`define LCG_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/lcg_pkg.sv -----
`timescale 1ns / 1ps
package lcg_pkg;
	localparam int MAX_COLS_DEF = 64;
	localparam int MAX_ROWS_DEF = 64;
	localparam int IDX_W = 11;
	localparam int PROG_W = 20;

	localparam logic [1:0] FN_LOAD = 2'd0;
	localparam logic [1:0] FN_SET  = 2'd1;
	localparam logic [1:0] FN_READ = 2'd2;
	localparam logic [1:0] FN_TICK = 2'd3;

	localparam logic REG_COLS = 1'b0;
	localparam logic REG_ROWS = 1'b1;
	localparam logic [6:0] AREA_RESET = 7'd64;

	typedef struct packed {
		logic [1:0]  func;
		logic [5:0]  col;
		logic [5:0]  row;
		logic        new_value;
		logic [15:0] truth_table;
		logic [3:0]  reach_bits;
	} cmd_t;

	typedef struct packed {
		logic read_value;
		logic done_res;
	} res_t;

	// bits 19:16 reach, 15:0 truth table
	typedef struct packed {
		logic [3:0]  reach;
		logic [15:0] tt;
	} prog_t;
endpackage

// ----- hdl/lcg_ram.sv -----
`timescale 1ns / 1ps
module lcg_ram import lcg_pkg::*; #(
	parameter int WIDTH = PROG_W,
	parameter int DEPTH = MAX_COLS_DEF * MAX_ROWS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/lcg_cell_eval.sv -----
`timescale 1ns / 1ps
module lcg_cell_eval import lcg_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic [MAX_COLS-1:0]         win [5],
	input  prog_t                       prog,
	input  logic [$clog2(MAX_COLS)-1:0] c,
	input  logic                        area,
	output logic                        nxt
);
	localparam int CW = $clog2(MAX_COLS);
	localparam int XW = CW + 2;

	logic [XW-1:0] cx, dr, dl, ri, li;
	logic          right, up, left, down;
	logic [3:0]    idx;

	always_comb begin
		cx = XW'(c);
		dr = prog.reach[0] ? XW'(2) : XW'(1);
		dl = prog.reach[2] ? XW'(2) : XW'(1);
		ri = cx + dr;
		li = cx - dl;
		// win[2] is the cell's own row, rows above and below around it
		right = (ri < XW'(MAX_COLS)) ? win[2][ri[CW-1:0]] : 1'b0;
		left  = (cx >= dl) ? win[2][li[CW-1:0]] : 1'b0;
		up    = prog.reach[1] ? win[0][c] : win[1][c];
		down  = prog.reach[3] ? win[4][c] : win[3][c];
		idx   = {down, left, up, right};
		nxt   = area & prog.tt[idx];
	end
endmodule

// ----- hdl/lut_cell_grid_logic_step_top.sv -----
`timescale 1ns / 1ps
// channel | dir | handshake            | word
// cmd     | in  | cmd_valid/cmd_ready  | cmd_t: func, col, row, new_value, truth_table, reach_bits
// res     | out | res_valid/res_ready  | res_t: read_value, done_res
// cfg     | in  | cfg_valid/cfg_ready  | cfg_index (0 cols, 1 rows), cfg_data
//
// Load goes straight to the finish state; set and read inside the area pass a row
// read/write state first. Finish waits while the previous result word is not taken.
// Tick works row by row: it fetches a five-row window, reads the program memory
// once per cell, then drains and writes the row back.
// After reset a clearing pass zeroes the program memory and the cell rows;
// no command word is taken then, config writes are.
// A result word that is not taken holds the next command in its finish state.
`include "assert_macros.svh"
module lut_cell_grid_logic_step_top import lcg_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	output logic       res_valid,
	input  logic       res_ready,
	output res_t       res,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data
);
	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int N  = MAX_COLS * MAX_ROWS;
	localparam int AW = $clog2(N);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RDW   = 3'd2;
	localparam logic [2:0] ST_FIN   = 3'd3;
	localparam logic [2:0] ST_WIN   = 3'd4;
	localparam logic [2:0] ST_CELL  = 3'd5;
	localparam logic [2:0] ST_DRAIN = 3'd6;
	localparam logic [2:0] ST_ROWWR = 3'd7;

	logic [2:0]    state_q;
	logic [AW-1:0] clr_q;
	logic          sel_q;       // 0: bank a holds the current generation
	logic [6:0]    cols_q, rows_q;
	logic          res_valid_q;
	res_t          res_q;
	cmd_t          cmd_q;
	logic          rv_q;
	logic [RW-1:0] tr_q;        // tick row
	logic [2:0]    wk_q;        // window fetch step
	logic [CW-1:0] cc_q;        // tick column issue
	logic          win_v_s1, win_ok_s1;
	logic [2:0]    win_idx_s1;
	logic          p_v_s1;
	logic [CW-1:0] p_c_s1;
	logic [MAX_COLS-1:0] win_q [5];
	logic [MAX_COLS-1:0] next_row_q;

	logic [IDX_W-1:0] gc, gr, act_cols, act_rows, rr_p2;
	logic [MAX_COLS-1:0] colmask, now_rd, rd_a, rd_b, mod_row, row_wdata;
	logic          accept, in_area, in_array, clearing;
	logic          set_we, tick_we, clr_row_we, we_a, we_b;
	logic [RW-1:0] row_raddr, row_waddr;
	logic          prog_we;
	logic [AW-1:0] prog_waddr, prog_raddr;
	prog_t         prog_wdata, prog_rd;
	logic          cell_nxt, cell_area, win_ok;

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign clearing  = (state_q == ST_CLEAR);

	// active area, capped at the array size
	always_comb begin
		gc = IDX_W'(cols_q);
		gr = IDX_W'(rows_q);
		act_cols = (gc > IDX_W'(MAX_COLS)) ? IDX_W'(MAX_COLS) : gc;
		act_rows = (gr > IDX_W'(MAX_ROWS)) ? IDX_W'(MAX_ROWS) : gr;
		for (int j = 0; j < MAX_COLS; j++) begin
			colmask[j] = IDX_W'(j) < act_cols;
		end
		in_array = (IDX_W'(cmd.col) < IDX_W'(MAX_COLS)) && (IDX_W'(cmd.row) < IDX_W'(MAX_ROWS));
		in_area  = (IDX_W'(cmd.col) < act_cols) && (IDX_W'(cmd.row) < act_rows);
	end

	// window row r-2+k; rows outside the area fetch as zero
	always_comb begin
		rr_p2  = IDX_W'(tr_q) + IDX_W'(wk_q);
		win_ok = (rr_p2 >= IDX_W'(2)) && ((rr_p2 - IDX_W'(2)) < act_rows);
	end

	always_comb begin
		now_rd = sel_q ? rd_b : rd_a;
		mod_row = now_rd;
		mod_row[CW'(cmd_q.col)] = cmd_q.new_value;

		row_raddr = (state_q == ST_WIN) ? RW'(rr_p2 - IDX_W'(2)) : RW'(cmd.row);
		set_we     = (state_q == ST_RDW) && (cmd_q.func == FN_SET);
		tick_we    = (state_q == ST_ROWWR);
		clr_row_we = clearing && (clr_q < AW'(MAX_ROWS));
		we_a = clr_row_we || (set_we && !sel_q) || (tick_we && sel_q);
		we_b = clr_row_we || (set_we && sel_q) || (tick_we && !sel_q);
		if (clearing) begin
			row_waddr = RW'(clr_q);
			row_wdata = '0;
		end else if (tick_we) begin
			row_waddr = tr_q;
			row_wdata = next_row_q;
		end else begin
			row_waddr = RW'(cmd_q.row);
			row_wdata = mod_row;
		end

		prog_we = clearing || (accept && (cmd.func == FN_LOAD) && in_array);
		if (clearing) begin
			prog_waddr = clr_q;
			prog_wdata = '0;
		end else begin
			prog_waddr = AW'(cmd.row) * AW'(MAX_COLS) + AW'(cmd.col);
			prog_wdata = '{reach: cmd.reach_bits, tt: cmd.truth_table};
		end
		prog_raddr = AW'(tr_q) * AW'(MAX_COLS) + AW'(cc_q);

		cell_area = (IDX_W'(p_c_s1) < act_cols) && (IDX_W'(tr_q) < act_rows);
	end

	lcg_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_bank_a (
		.clk(clk), .we(we_a), .waddr(row_waddr), .wdata(row_wdata),
		.raddr(row_raddr), .rdata(rd_a)
	);

	lcg_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_bank_b (
		.clk(clk), .we(we_b), .waddr(row_waddr), .wdata(row_wdata),
		.raddr(row_raddr), .rdata(rd_b)
	);

	lcg_ram #(.WIDTH(PROG_W), .DEPTH(N)) u_prog (
		.clk(clk), .we(prog_we), .waddr(prog_waddr), .wdata(prog_wdata),
		.raddr(prog_raddr), .rdata(prog_rd)
	);

	lcg_cell_eval #(.MAX_COLS(MAX_COLS)) u_eval (
		.win(win_q), .prog(prog_rd), .c(p_c_s1), .area(cell_area), .nxt(cell_nxt)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			sel_q       <= 1'b0;
			cols_q      <= AREA_RESET;
			rows_q      <= AREA_RESET;
			res_valid_q <= 1'b0;
			win_v_s1    <= 1'b0;
			p_v_s1      <= 1'b0;
			tr_q        <= '0;
			wk_q        <= '0;
			cc_q        <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COLS: cols_q <= cfg_data;
					REG_ROWS: rows_q <= cfg_data;
					default: ;
				endcase
			end
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			win_v_s1 <= 1'b0;
			p_v_s1   <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(N - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (cmd.func)
							FN_SET, FN_READ: state_q <= in_area ? ST_RDW : ST_FIN;
							FN_TICK: begin
								tr_q    <= '0;
								wk_q    <= '0;
								state_q <= ST_WIN;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_RDW: state_q <= ST_FIN;
				ST_FIN: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_WIN: begin
					if (wk_q == 3'd5) begin
						cc_q    <= '0;
						state_q <= ST_CELL;
					end else begin
						win_v_s1 <= 1'b1;
						wk_q     <= wk_q + 1'b1;
					end
				end
				ST_CELL: begin
					p_v_s1 <= 1'b1;
					cc_q   <= cc_q + 1'b1;
					if (cc_q == CW'(MAX_COLS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_ROWWR;
				ST_ROWWR: begin
					if (tr_q == RW'(MAX_ROWS - 1)) begin
						sel_q   <= ~sel_q;  // new generation becomes current
						state_q <= ST_FIN;
					end else begin
						tr_q    <= tr_q + 1'b1;
						wk_q    <= '0;
						state_q <= ST_WIN;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			rv_q  <= 1'b0;
		end
		if (state_q == ST_RDW && cmd_q.func == FN_READ) begin
			rv_q <= now_rd[CW'(cmd_q.col)];
		end
		if (state_q == ST_FIN && (!res_valid_q || res_ready)) begin
			res_q <= '{read_value: rv_q, done_res: 1'b1};
		end
		win_idx_s1 <= wk_q;
		win_ok_s1  <= win_ok;
		if (win_v_s1) begin
			win_q[win_idx_s1] <= win_ok_s1 ? (now_rd & colmask) : '0;
		end
		p_c_s1 <= cc_q;
		if (p_v_s1) begin
			next_row_q[p_c_s1] <= cell_nxt;
		end
	end

	`LCG_ASSERT_IMP(ap_res_from_fin, $rose(res_valid_q), $past(state_q) == ST_FIN, "result without finish")
	`LCG_ASSERT_NXT(ap_sel_hold, state_q != ST_ROWWR, $stable(sel_q), "bank swap outside row write")
	`LCG_ASSERT_IMP(ap_cell_phase, p_v_s1, state_q == ST_CELL || state_q == ST_DRAIN, "stray cell data")
	`LCG_ASSERT_IMP(ap_win_done, state_q == ST_CELL, !win_v_s1, "window not complete")
endmodule
